### hdl/psa_pkg.sv
// Shared types, constants and the byte-wide CRC-32 step for the PSI section assembler.
// No dependencies; every other file in hdl/ imports this package.
package psa_pkg;

   localparam int unsigned CNT_W = 13;
   localparam int unsigned LEN_W = 12;
   localparam int unsigned HDR_BYTES = 8;
   localparam int unsigned HDR_IDX_W = $clog2(HDR_BYTES);

   localparam logic [CNT_W-1:0] HDR_PREFIX = CNT_W'(3);
   localparam logic [CNT_W-1:0] LEN_BYTE_POS = CNT_W'(2);
   localparam logic [CNT_W-1:0] HDR_FULL_CNT = CNT_W'(HDR_BYTES);

   localparam logic [LEN_W-1:0] MIN_LEN_SYNTAX = LEN_W'(9);
   localparam logic [LEN_W-1:0] MIN_LEN_PLAIN = LEN_W'(4);

   localparam logic [7:0] TID_CRC_A = 8'h73;
   localparam logic [7:0] TID_CRC_B = 8'hC5;
   localparam logic [7:0] TID_CRC_C = 8'hCD;

   localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   typedef struct packed {
      logic        valid;
      logic [7:0]  data_byte;
      logic        section_start;
   } in_item_type;

   typedef struct packed {
      logic [7:0]  tid;
      logic        syn;
      logic        priv;
      logic [15:0] ext;
      logic [4:0]  ver;
      logic        cni;
      logic [7:0]  secno;
      logic [7:0]  lastno;
   } hdr_type;

   localparam hdr_type HDR_RESET = '{
      tid: 8'h00, syn: 1'b1, priv: 1'b1, ext: 16'h0000,
      ver: 5'd0, cni: 1'b1, secno: 8'hFF, lastno: 8'hFF
   };

   typedef struct packed {
      logic             consumed;
      logic             complete;
      logic             valid_res;
      logic [7:0]       tbl_id;
      logic             syntax_flag;
      logic             private_flag;
      logic [LEN_W-1:0] sect_len;
      logic [15:0]      tbl_id_ext;
      logic [4:0]       ver_num;
      logic             current_next;
      logic [7:0]       section_number;
      logic [7:0]       last_section_number;
   } rsp_type;

   // MSB-first CRC-32 update over one byte, no reflection
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {b, 24'h000000};
      for (int i = 0; i < 8; i++) begin
         if (c[31]) begin
            c = {c[30:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[30:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

### hdl/psi_section_assembler.sv
// Top level of the MPEG-2 PSI section assembler with CRC-32 check.
// Depends on psa_pkg, psa_in_reg and psa_engine.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   data_byte, section_start
//   rsp_      out        rsp_valid/rsp_stall   consumed ... last_section_number
//
// One item per clock cycle sustained while results are not stalled; an item
// passes the input register, then the result register. The byte-wide CRC-32
// update plus the completion compare both lie between the input register and
// the result register. Reset is synchronous and active high and empties both registers.
// A stalled result holds in the result register while the input register can still
// take an item if it is empty; req_stall is high while it holds one.
module psi_section_assembler
   import psa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,

   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_data_byte,
   input  logic             req_section_start,

   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_consumed,
   output logic             rsp_complete,
   output logic             rsp_valid_res,
   output logic [7:0]       rsp_tbl_id,
   output logic             rsp_syntax_flag,
   output logic             rsp_private_flag,
   output logic [LEN_W-1:0] rsp_sect_len,
   output logic [15:0]      rsp_tbl_id_ext,
   output logic [4:0]       rsp_ver_num,
   output logic             rsp_current_next,
   output logic [7:0]       rsp_section_number,
   output logic [7:0]       rsp_last_section_number
);

   in_item_type item;
   rsp_type     rsp_in;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic        advance;

   // advance the pipe whenever the result register is empty or being taken
   assign advance = !rsp_valid_ff || !rsp_stall;

   psa_in_reg u_in_reg (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_section_start (req_section_start),
      .advance           (advance),
      .item              (item)
   );

   psa_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .item    (item),
      .advance (advance),
      .rsp_in  (rsp_in)
   );

   // hold the result while stalled, otherwise load whatever the step produced
   assign rsp_valid_in = advance ? item.valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && item.valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_consumed            = rsp_ff.consumed;
   assign rsp_complete            = rsp_ff.complete;
   assign rsp_valid_res           = rsp_ff.valid_res;
   assign rsp_tbl_id              = rsp_ff.tbl_id;
   assign rsp_syntax_flag         = rsp_ff.syntax_flag;
   assign rsp_private_flag        = rsp_ff.private_flag;
   assign rsp_sect_len            = rsp_ff.sect_len;
   assign rsp_tbl_id_ext          = rsp_ff.tbl_id_ext;
   assign rsp_ver_num             = rsp_ff.ver_num;
   assign rsp_current_next        = rsp_ff.current_next;
   assign rsp_section_number      = rsp_ff.section_number;
   assign rsp_last_section_number = rsp_ff.last_section_number;

endmodule

### hdl/psa_in_reg.sv
// Input register of the PSI section assembler: holds one request item.
// Depends on psa_pkg (in_item_type).
module psa_in_reg
   import psa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_section_start,
   input  logic        advance,
   output in_item_type item
);

   in_item_type item_ff;
   in_item_type item_in;
   logic        accept;

   assign req_stall = item_ff.valid && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      item_in = item_ff;
      if (accept) begin
         item_in.valid         = 1'b1;
         item_in.data_byte     = req_data_byte;
         item_in.section_start = req_section_start;
      end else if (advance) begin
         item_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else begin
         item_ff.valid <= item_in.valid;
      end
      item_ff.data_byte     <= item_in.data_byte;
      item_ff.section_start <= item_in.section_start;
   end

   assign item = item_ff;

endmodule

### hdl/psa_engine.sv
// Section state and single-pass step logic: count, length, header bytes, CRC, commit, checks.
// Depends on psa_pkg (types, constants, crc_byte).
module psa_engine
   import psa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  in_item_type item,
   input  logic        advance,
   output rsp_type     rsp_in
);

   logic [CNT_W-1:0] count_ff, count_in, cnt_e;
   logic [LEN_W-1:0] len_ff, len_in, len_e;
   logic [31:0]      crc_ff, crc_in, crc_e;
   logic [31:0]      last_ff, last_in, last_e;
   hdr_type          commit_ff, commit_in, commit_e;
   logic [7:0]       hdr_ff [HDR_BYTES];
   logic [7:0]       hdr_in [HDR_BYTES];

   logic fire;
   logic done_pre;
   logic take;
   logic done;
   logic crc_needed;
   logic [LEN_W-1:0] min_len;
   logic checks_ok;

   assign fire = item.valid && advance;

   always_comb begin
      // start clears the state before the byte is taken
      cnt_e    = item.section_start ? '0 : count_ff;
      len_e    = item.section_start ? '0 : len_ff;
      crc_e    = item.section_start ? CRC_INIT : crc_ff;
      last_e   = item.section_start ? '0 : last_ff;
      commit_e = item.section_start ? HDR_RESET : commit_ff;

      done_pre = cnt_e >= (HDR_PREFIX + CNT_W'(len_e));
      take     = (cnt_e < HDR_PREFIX) || !done_pre;

      hdr_in = hdr_ff;
      if (take && (cnt_e < HDR_FULL_CNT)) begin
         hdr_in[cnt_e[HDR_IDX_W-1:0]] = item.data_byte;
      end

      len_in   = len_e;
      crc_in   = crc_e;
      last_in  = last_e;
      count_in = cnt_e;
      if (take) begin
         if (cnt_e == LEN_BYTE_POS) begin
            len_in = {hdr_ff[1][3:0], item.data_byte};
         end
         crc_in   = crc_byte(crc_e, item.data_byte);
         last_in  = {last_e[23:0], item.data_byte};
         count_in = cnt_e + CNT_W'(1);
      end

      done = count_in >= (HDR_PREFIX + CNT_W'(len_in));

      commit_in = commit_e;
      if (take && done) begin
         commit_in.tid  = hdr_in[0];
         commit_in.syn  = hdr_in[1][7];
         commit_in.priv = hdr_in[1][6];
         if (hdr_in[1][7] && (count_in >= HDR_FULL_CNT)) begin
            commit_in.ext    = {hdr_in[3], hdr_in[4]};
            commit_in.ver    = hdr_in[5][5:1];
            commit_in.cni    = hdr_in[5][0];
            commit_in.secno  = hdr_in[6];
            commit_in.lastno = hdr_in[7];
         end
      end

      crc_needed = commit_in.syn || (commit_in.tid == TID_CRC_A)
                   || (commit_in.tid == TID_CRC_B) || (commit_in.tid == TID_CRC_C);
      min_len    = commit_in.syn ? MIN_LEN_SYNTAX : MIN_LEN_PLAIN;
      checks_ok  = !crc_needed || ((len_in >= min_len)
                   && ((crc_in == '0) || (last_in == '0) || (last_in == '1)));

      rsp_in.consumed            = take;
      rsp_in.complete            = done;
      rsp_in.valid_res           = done && checks_ok;
      rsp_in.tbl_id              = commit_in.tid;
      rsp_in.syntax_flag         = commit_in.syn;
      rsp_in.private_flag        = commit_in.priv;
      rsp_in.sect_len            = len_in;
      rsp_in.tbl_id_ext          = commit_in.ext;
      rsp_in.ver_num             = commit_in.ver;
      rsp_in.current_next        = commit_in.cni;
      rsp_in.section_number      = commit_in.secno;
      rsp_in.last_section_number = commit_in.lastno;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         len_ff    <= '0;
         crc_ff    <= CRC_INIT;
         last_ff   <= '0;
         commit_ff <= HDR_RESET;
      end else if (fire) begin
         count_ff  <= count_in;
         len_ff    <= len_in;
         crc_ff    <= crc_in;
         last_ff   <= last_in;
         commit_ff <= commit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         hdr_ff <= hdr_in;
      end
   end

`ifndef SYNTHESIS
   // count never runs past the end of the section
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= HDR_PREFIX) |-> (count_ff <= HDR_PREFIX + CNT_W'(len_ff)))
      else $error("byte count beyond section end");

   // an ignored byte leaves the section state alone
   a_drop_holds: assert property (@(posedge clock) disable iff (reset)
      (fire && !take) |=> ($stable(count_ff) && $stable(crc_ff) && $stable(last_ff)))
      else $error("ignored byte changed section state");

   // length loads only from the third byte of a section
   a_len_load: assert property (@(posedge clock) disable iff (reset)
      (fire && !item.section_start && (count_ff != LEN_BYTE_POS)) |=> $stable(len_ff))
      else $error("section length changed outside byte two");
`endif

endmodule

### tb/psi_section_assembler_tb.sv
// Self-checking testbench for psi_section_assembler: directed and random PSI sections.
// Depends on psa_pkg and the RTL under hdl/; needs no files or arguments at run time.
module psi_section_assembler_tb;
   import psa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Cycles with no item accepted on either channel before the run is declared hung
   localparam int QUIET_LIMIT = 2000;
   // Stop random stimulus once this many bytes have gone into sections
   localparam int TAKEN_TARGET = 1700;

   // How the last four bytes of a generated section are filled
   typedef enum logic [1:0] {
      TAIL_CRC,
      TAIL_ZERO,
      TAIL_ONES,
      TAIL_RAND
   } tail_type;

   // Receiver stall behavior, switched at random from time to time by the receiver
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_mode_type;

   // Section state tracker: predicts one result item per accepted byte and
   // checks the block's result items against those predictions in order.
   class psi_scoreboard;
      logic [CNT_W-1:0] n_bytes;
      logic [LEN_W-1:0] sec_len;
      logic [7:0]       hdr_raw [HDR_BYTES];
      logic [31:0]      crc;
      logic [31:0]      tail4;
      hdr_type          hdr;
      rsp_type          rsp_due [$];
      int               n_taken;
      int               errors;

      function new();
         n_taken = 0;
         errors = 0;
         clear_state();
      endfunction

      function void clear_state();
         n_bytes = '0;
         sec_len = '0;
         foreach (hdr_raw[i]) hdr_raw[i] = 8'h00;
         crc = CRC_INIT;
         tail4 = '0;
         hdr = HDR_RESET;
      endfunction

      // Bit-serial form of the MPEG-2 CRC-32 step, MSB first
      function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
         logic fb;
         for (int i = 7; i >= 0; i--) begin
            fb = c[31] ^ b[i];
            c = {c[30:0], 1'b0};
            if (fb) c = c ^ CRC_POLY;
         end
         return c;
      endfunction

      function bit all_in();
         return n_bytes >= HDR_PREFIX + CNT_W'(sec_len);
      endfunction

      function bit passes();
         logic [LEN_W-1:0] floor_len;
         if (!all_in()) return 1'b0;
         if (hdr.syn) begin
            floor_len = MIN_LEN_SYNTAX;
         end else if (hdr.tid == TID_CRC_A || hdr.tid == TID_CRC_B || hdr.tid == TID_CRC_C) begin
            floor_len = MIN_LEN_PLAIN;
         end else begin
            return 1'b1;
         end
         if (sec_len < floor_len) return 1'b0;
         return (crc == 32'h0) || (tail4 == 32'h0) || (tail4 == 32'hFFFF_FFFF);
      endfunction

      function int pending();
         return rsp_due.size();
      endfunction

      function void note_byte(logic [7:0] b, logic start);
         logic    take;
         logic    done;
         rsp_type r;
         if (start) clear_state();
         take = (n_bytes < HDR_PREFIX) || !all_in();
         if (take) begin
            if (n_bytes < HDR_FULL_CNT) hdr_raw[n_bytes[HDR_IDX_W-1:0]] = b;
            if (n_bytes == LEN_BYTE_POS) sec_len = {hdr_raw[1][3:0], b};
            crc = crc_step(crc, b);
            tail4 = {tail4[23:0], b};
            n_bytes++;
            n_taken++;
         end
         done = all_in();
         if (take && done) begin
            hdr.tid = hdr_raw[0];
            hdr.syn = hdr_raw[1][7];
            hdr.priv = hdr_raw[1][6];
            if (hdr.syn && n_bytes >= HDR_FULL_CNT) begin
               hdr.ext = {hdr_raw[3], hdr_raw[4]};
               hdr.ver = hdr_raw[5][5:1];
               hdr.cni = hdr_raw[5][0];
               hdr.secno = hdr_raw[6];
               hdr.lastno = hdr_raw[7];
            end
         end
         r.consumed = take;
         r.complete = done;
         r.valid_res = passes();
         r.tbl_id = hdr.tid;
         r.syntax_flag = hdr.syn;
         r.private_flag = hdr.priv;
         r.sect_len = sec_len;
         r.tbl_id_ext = hdr.ext;
         r.ver_num = hdr.ver;
         r.current_next = hdr.cni;
         r.section_number = hdr.secno;
         r.last_section_number = hdr.lastno;
         rsp_due.push_back(r);
      endfunction

      function void cmp(string what, logic [15:0] want, logic [15:0] seen);
         if (seen !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, seen);
         end
      endfunction

      function void check_rsp(rsp_type got);
         rsp_type want;
         if (rsp_due.size() == 0) begin
            errors++;
            $display("%0t: result item with nothing expected, expected none, got %h", $time, got);
         end else begin
            want = rsp_due.pop_front();
            cmp("consumed", want.consumed, got.consumed);
            cmp("complete", want.complete, got.complete);
            cmp("valid_res", want.valid_res, got.valid_res);
            cmp("tbl_id", want.tbl_id, got.tbl_id);
            cmp("syntax_flag", want.syntax_flag, got.syntax_flag);
            cmp("private_flag", want.private_flag, got.private_flag);
            cmp("sect_len", want.sect_len, got.sect_len);
            cmp("tbl_id_ext", want.tbl_id_ext, got.tbl_id_ext);
            cmp("ver_num", want.ver_num, got.ver_num);
            cmp("current_next", want.current_next, got.current_next);
            cmp("section_number", want.section_number, got.section_number);
            cmp("last_section_number", want.last_section_number, got.last_section_number);
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [7:0]       req_data_byte;
   logic             req_section_start;
   logic             rsp_valid;
   logic             rsp_stall;
   logic             rsp_consumed;
   logic             rsp_complete;
   logic             rsp_valid_res;
   logic [7:0]       rsp_tbl_id;
   logic             rsp_syntax_flag;
   logic             rsp_private_flag;
   logic [LEN_W-1:0] rsp_sect_len;
   logic [15:0]      rsp_tbl_id_ext;
   logic [4:0]       rsp_ver_num;
   logic             rsp_current_next;
   logic [7:0]       rsp_section_number;
   logic [7:0]       rsp_last_section_number;

   psi_scoreboard sb = new();

   // Sender pacing: in gappy mode, bursts of random length separated by idle gaps
   bit gappy = 1'b0;
   int burst_left = 0;

   // Receiver stall pattern state
   int             stall_cycle = 0;
   stall_mode_type stall_mode = STALL_NONE;

   // Watchdog: cycles since the last accepted item on either channel
   int quiet_cycles = 0;

   psi_section_assembler u_dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_data_byte           (req_data_byte),
      .req_section_start       (req_section_start),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_consumed            (rsp_consumed),
      .rsp_complete            (rsp_complete),
      .rsp_valid_res           (rsp_valid_res),
      .rsp_tbl_id              (rsp_tbl_id),
      .rsp_syntax_flag         (rsp_syntax_flag),
      .rsp_private_flag        (rsp_private_flag),
      .rsp_sect_len            (rsp_sect_len),
      .rsp_tbl_id_ext          (rsp_tbl_id_ext),
      .rsp_ver_num             (rsp_ver_num),
      .rsp_current_next        (rsp_current_next),
      .rsp_section_number      (rsp_section_number),
      .rsp_last_section_number (rsp_last_section_number)
   );

   // 10 ns clock, low phase first
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Receiver: change stall only at the falling edge and re-pick the stall mode at random,
   // so that quiet stretches, random stalls, a fixed pattern and heavy back-pressure
   // all get their turn.
   always @(negedge clock) begin
      stall_cycle++;
      if (stall_cycle % 300 == 0) stall_mode = stall_mode_type'($urandom_range(0, 3));
      case (stall_mode)
         STALL_NONE: rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 99) < 25);
         STALL_PERIODIC: rsp_stall <= ((stall_cycle % 7) < 3);
         default: rsp_stall <= ($urandom_range(0, 99) < 70);
      endcase
   end

   // Monitor: sample both channels at the rising edge. Note the input item first,
   // then check the result item; with the input and result registers in between,
   // they never refer to the same byte. Also run the watchdog here.
   always @(posedge clock) begin : monitor
      rsp_type got;
      if (!reset) begin
         quiet_cycles++;
         if (req_valid && !req_stall) begin
            sb.note_byte(req_data_byte, req_section_start);
            quiet_cycles = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_consumed, rsp_complete, rsp_valid_res, rsp_tbl_id,
                   rsp_syntax_flag, rsp_private_flag, rsp_sect_len,
                   rsp_tbl_id_ext, rsp_ver_num, rsp_current_next,
                   rsp_section_number, rsp_last_section_number};
            sb.check_rsp(got);
            quiet_cycles = 0;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no item accepted for %0d cycles, %0d results outstanding",
                     $time, QUIET_LIMIT, sb.pending());
            $display("psi_section_assembler_tb: done, errors");
            $finish;
         end
      end
   end

   // Drive one byte at the falling edge and hold it until the block takes it.
   // In gappy mode, drop valid for a random gap once the current burst runs out.
   task automatic put_byte(input logic [7:0] b, input logic start);
      if (gappy && burst_left == 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_section_start <= start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (burst_left > 0) burst_left--;
   endtask

   // Build a section: table id, flags nibble plus length, then a random body whose
   // last four bytes follow the tail mode. Send the first n_send bytes (all if
   // negative), raising the start flag on byte 0.
   task automatic put_section(input logic [7:0] tid, input logic [3:0] flags,
                              input logic [11:0] len, input tail_type tail, input int n_send);
      logic [7:0]  sec [$];
      logic [31:0] c;
      int          total;
      int          i;
      int          k;
      sec.push_back(tid);
      sec.push_back({flags, len[11:8]});
      sec.push_back(len[7:0]);
      for (i = 0; i < len; i++) sec.push_back(8'($urandom));
      total = sec.size();
      if (len >= 4) begin
         case (tail)
            TAIL_CRC: begin
               // Append the CRC big endian so that the residue comes out zero
               c = CRC_INIT;
               for (i = 0; i < total - 4; i++) c = sb.crc_step(c, sec[i]);
               for (k = 0; k < 4; k++) sec[total-4+k] = c[31-8*k -: 8];
            end
            TAIL_ZERO: for (k = 0; k < 4; k++) sec[total-4+k] = 8'h00;
            TAIL_ONES: for (k = 0; k < 4; k++) sec[total-4+k] = 8'hFF;
            default: ;
         endcase
      end
      if (n_send < 0 || n_send > total) n_send = total;
      for (i = 0; i < n_send; i++) put_byte(sec[i], i == 0);
   endtask

   // Hold the sender idle until every expected result item has come back
   task automatic wait_drained();
      @(negedge clock) req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int          pick;
      int          n_sections;
      logic [7:0]  tid;
      logic [11:0] len;
      tail_type    tail;

      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'h00;
      req_section_start = 1'b0;
      rsp_stall = 1'b0;
      n_sections = 0;
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed part.
      // Empty section with no CRC expected, then a byte after completion to drop.
      put_section(8'hFF, 4'b0000, 12'd0, TAIL_RAND, -1);
      put_byte(8'hFF, 1'b0);
      // Plain section on a CRC-carrying table id, minimum length, good CRC.
      put_section(TID_CRC_B, 4'b0011, 12'd4, TAIL_CRC, -1);
      gappy = 1'b1;
      // Syntax section at its minimum length, all-ones filler in place of a CRC,
      // long enough to commit the extended header.
      put_section(8'h00, 4'b1000, 12'd9, TAIL_ONES, -1);
      // Syntax section too short: zero filler, and too few bytes for the
      // extended header, so those fields stay at their reset values.
      put_section(TID_CRC_C, 4'b1100, 12'd4, TAIL_ZERO, -1);
      // Largest length field, cut off by the next start.
      put_section(8'h42, 4'b1111, 12'hFFF, TAIL_RAND, 3);
      wait_drained();

      // Random part: mostly well-formed sections with random content, some cut
      // short, some raw noise with a rare start flag.
      while (sb.n_taken < TAKEN_TARGET) begin
         gappy = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            case ($urandom_range(0, 3))
               0: tid = TID_CRC_A;
               1: tid = TID_CRC_B;
               2: tid = TID_CRC_C;
               default: tid = 8'($urandom);
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 85) len = 12'($urandom_range(0, 24));
            else if (pick < 97) len = 12'($urandom_range(25, 100));
            else len = 12'($urandom_range(101, 600));
            pick = $urandom_range(0, 99);
            if (pick < 60) tail = TAIL_CRC;
            else if (pick < 72) tail = TAIL_ZERO;
            else if (pick < 84) tail = TAIL_ONES;
            else tail = TAIL_RAND;
            put_section(tid, 4'($urandom), len, tail, -1);
            // Trailing bytes past completion must be dropped
            repeat ($urandom_range(0, 3)) put_byte(8'($urandom), 1'b0);
         end else if (pick < 85) begin
            put_section(8'($urandom), 4'($urandom), 12'($urandom), TAIL_RAND,
                        $urandom_range(1, 23));
         end else begin
            repeat ($urandom_range(1, 8)) put_byte(8'($urandom), $urandom_range(0, 9) == 0);
         end
         n_sections++;
         if (n_sections % 25 == 0) wait_drained();
      end

      // Let everything come back, then keep the sender idle and the clock running
      // so that any stray result item still shows up.
      wait_drained();
      repeat (8) @(posedge clock);
      if (sb.errors == 0) begin
         $display("psi_section_assembler_tb: done, clean");
      end else begin
         $display("psi_section_assembler_tb: done, errors");
      end
      $finish;
   end

endmodule
